@@ hw/rtl/paillier_cipher_unit_top_defines.svh @@
`ifndef PAILLIER_CIPHER_UNIT_TOP_DEFINES_SVH
`define PAILLIER_CIPHER_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PCU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcu: same-cycle check failed");

// Next-cycle implication.
`define PCU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcu: next-cycle check failed");

`endif

@@ hw/rtl/pcu_pkg.sv @@
package pcu_pkg;

	localparam int OP_W        = 2;
	localparam int DATA_W      = 16;
	localparam int CIPH_W      = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_TDATA_W  = 120;
	localparam int OUT_TDATA_W = 40;
	localparam int STEP_W      = 5;
	localparam int N_BITS_DEF  = 16;

	typedef enum logic [OP_W-1:0] {
		OP_ENCRYPT = 2'd0,
		OP_DECRYPT = 2'd1,
		OP_ADD     = 2'd2,
		OP_SCALAR  = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_N      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MU     = 2'd3;

	typedef enum logic [2:0] {
		A_ONE, A_BASE, A_PACC, A_HEAD, A_QUOT
	} a_sel_t;

	typedef enum logic [2:0] {
		B_CA, B_CB, B_R, B_NM1, B_BASE, B_PACC, B_XM1, B_MU
	} b_sel_t;

	typedef enum logic [2:0] {
		D_BASE, D_PACC, D_HEAD, D_QUOT, D_RES
	} dst_t;

	typedef struct packed {
		logic   load;
		logic   start;
		a_sel_t a_sel;
		b_sel_t b_sel;
		dst_t   dst;
		logic   mod_n;
		logic   shift_exp;
		logic   publish;
		logic   err;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic exp_zero;
		logic exp_bit0;
		logic n_small;
		logic mode;
	} dp_stat_t;

endpackage

@@ hw/rtl/pcu_datapath.sv @@
module pcu_datapath #(
	parameter int N_BITS = pcu_pkg::N_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [pcu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pcu_pkg::DATA_W-1:0]         cfg_data,
	input  logic [pcu_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  pcu_pkg::dp_cmd_t                   cmd,
	output pcu_pkg::dp_stat_t                  stat,
	output logic [pcu_pkg::OUT_TDATA_W-1:0]    out_data
);
	import pcu_pkg::*;

	localparam int NB = (N_BITS < DATA_W) ? N_BITS : DATA_W;

	logic              mode_q;
	logic [NB-1:0]     mod_n_q;
	logic [DATA_W-1:0] lambda_q, mu_q;

	logic [DATA_W-1:0] n_act;
	logic [OP_W-1:0]   in_op;
	logic [DATA_W-1:0] in_m, in_r, in_k;
	logic [CIPH_W-1:0] in_ca, in_cb;

	logic [DATA_W-1:0] r_q, exp_q;
	logic [CIPH_W-1:0] ca_q, cb_q, n2_q, nm1_q;
	logic [CIPH_W-1:0] base_q, pacc_q, head_q, quot_q, res_q, qsh_q, acc_q;
	logic              eng_busy_q;
	logic [STEP_W-1:0] step_q;
	logic [CIPH_W:0]   out_q;

	logic [CIPH_W-1:0] a_val, b_val, modv, xm1, new_acc;
	logic [CIPH_W+1:0] t0, t1, t2, modx;
	logic              bit_b, ge1, done;

	assign in_op = s_tdata[1:0];
	assign in_m  = s_tdata[17:2];
	assign in_r  = s_tdata[33:18];
	assign in_ca = s_tdata[65:34];
	assign in_cb = s_tdata[97:66];
	assign in_k  = s_tdata[113:98];

	assign n_act = DATA_W'(mod_n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			mod_n_q  <= NB'(2);
			lambda_q <= '0;
			mu_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[0];
				CFG_N:      mod_n_q  <= cfg_data[NB-1:0];
				CFG_LAMBDA: lambda_q <= cfg_data;
				CFG_MU:     mu_q     <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Operand selection for the shift-add modular multiplier.
	always_comb begin
		case (cmd.a_sel)
			A_ONE:   a_val = CIPH_W'(1);
			A_BASE:  a_val = base_q;
			A_PACC:  a_val = pacc_q;
			A_HEAD:  a_val = head_q;
			A_QUOT:  a_val = quot_q;
			default: a_val = CIPH_W'(1);
		endcase
	end

	// A zero power decrypts to zero, so x - 1 is clamped at zero.
	assign xm1 = (pacc_q == '0) ? '0 : pacc_q - CIPH_W'(1);

	always_comb begin
		case (cmd.b_sel)
			B_CA:    b_val = ca_q;
			B_CB:    b_val = cb_q;
			B_R:     b_val = CIPH_W'(r_q);
			B_NM1:   b_val = nm1_q;
			B_BASE:  b_val = base_q;
			B_PACC:  b_val = pacc_q;
			B_XM1:   b_val = xm1;
			B_MU:    b_val = CIPH_W'(mu_q);
			default: b_val = ca_q;
		endcase
	end

	assign modv  = cmd.mod_n ? CIPH_W'(n_act) : n2_q;
	assign modx  = (CIPH_W+2)'(modv);
	assign bit_b = b_val[STEP_W'(CIPH_W-1) - step_q];

	// One bit of b per cycle, most significant first: acc = 2*acc + bit*a mod M.
	// With a equal to one the first compare is the restoring-division quotient bit.
	assign t0      = {1'b0, acc_q, 1'b0} + (bit_b ? (CIPH_W+2)'(a_val) : '0);
	assign ge1     = (t0 >= modx);
	assign t1      = ge1 ? t0 - modx : t0;
	assign t2      = (t1 >= modx) ? t1 - modx : t1;
	assign new_acc = t2[CIPH_W-1:0];
	assign done    = eng_busy_q && (step_q == STEP_W'(CIPH_W-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_busy_q <= 1'b0;
			step_q     <= '0;
		end else if (cmd.start) begin
			eng_busy_q <= 1'b1;
			step_q     <= '0;
		end else if (eng_busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (done)
				eng_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (eng_busy_q) begin
			acc_q <= new_acc;
			qsh_q <= {qsh_q[CIPH_W-2:0], ge1};
		end
		if (cmd.load) begin
			r_q    <= in_r;
			ca_q   <= in_ca;
			cb_q   <= in_cb;
			n2_q   <= CIPH_W'(n_act) * CIPH_W'(n_act);
			nm1_q  <= CIPH_W'(n_act) * CIPH_W'(in_m) + CIPH_W'(1);
			pacc_q <= CIPH_W'(1);
			case (op_t'(in_op))
				OP_ENCRYPT: exp_q <= n_act;
				OP_DECRYPT: exp_q <= lambda_q;
				OP_SCALAR:  exp_q <= in_k;
				default:    exp_q <= '0;
			endcase
		end else if (cmd.shift_exp) begin
			exp_q <= exp_q >> 1;
		end
		if (done) begin
			case (cmd.dst)
				D_BASE:  base_q <= new_acc;
				D_PACC:  pacc_q <= new_acc;
				D_HEAD:  head_q <= new_acc;
				D_QUOT:  quot_q <= {qsh_q[CIPH_W-2:0], ge1};
				D_RES:   res_q  <= new_acc;
				default: ;
			endcase
		end
		if (cmd.publish)
			out_q <= {cmd.err, (cmd.err || stat.n_small) ? CIPH_W'(0) : res_q};
	end

	assign stat.mul_done = done;
	assign stat.exp_zero = (exp_q == '0);
	assign stat.exp_bit0 = exp_q[0];
	assign stat.n_small  = (n_act < DATA_W'(2));
	assign stat.mode     = mode_q;

	assign out_data = OUT_TDATA_W'(out_q);
endmodule

@@ hw/rtl/pcu_ctrl.sv @@
module pcu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  pcu_pkg::op_t      op,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  pcu_pkg::dp_stat_t stat,
	output pcu_pkg::dp_cmd_t  cmd
);
	import pcu_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_E_HEAD, S_E_BASE, S_B_CA, S_P_TEST, S_P_MUL, S_P_SQR,
		S_D_DIV, S_D_MU, S_A_MUL, S_K_COPY, S_E_FIN, S_PUBLISH
	} state_t;

	state_t state_q, after_mul;
	op_t    op_q;
	logic   err_q, busy_q, valid_q;
	logic   is_mul, accept, bad_mode, out_free;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign bad_mode = (op == OP_ENCRYPT && stat.mode) || (op == OP_DECRYPT && !stat.mode);
	assign out_free = !valid_q || m_tready;
	assign m_tvalid = valid_q;

	always_comb begin
		cmd       = '0;
		cmd.a_sel = A_ONE;
		cmd.b_sel = B_CA;
		cmd.dst   = D_RES;
		is_mul    = 1'b1;
		after_mul = S_PUBLISH;
		case (state_q)
			S_IDLE: begin
				is_mul   = 1'b0;
				cmd.load = accept;
			end
			S_E_HEAD: begin
				cmd.b_sel = B_NM1;
				cmd.dst   = D_HEAD;
				after_mul = S_E_BASE;
			end
			S_E_BASE: begin
				cmd.b_sel = B_R;
				cmd.dst   = D_BASE;
				after_mul = S_P_TEST;
			end
			S_B_CA: begin
				cmd.dst   = D_BASE;
				after_mul = (op_q == OP_ADD) ? S_A_MUL : S_P_TEST;
			end
			S_P_TEST: begin
				is_mul        = 1'b0;
				cmd.shift_exp = !stat.exp_zero;
			end
			S_P_MUL: begin
				cmd.a_sel = A_PACC;
				cmd.b_sel = B_BASE;
				cmd.dst   = D_PACC;
				after_mul = S_P_SQR;
			end
			S_P_SQR: begin
				cmd.a_sel = A_BASE;
				cmd.b_sel = B_BASE;
				cmd.dst   = D_BASE;
				after_mul = S_P_TEST;
			end
			S_D_DIV: begin
				cmd.b_sel = B_XM1;
				cmd.dst   = D_QUOT;
				cmd.mod_n = 1'b1;
				after_mul = S_D_MU;
			end
			S_D_MU: begin
				cmd.a_sel = A_QUOT;
				cmd.b_sel = B_MU;
				cmd.mod_n = 1'b1;
			end
			S_A_MUL: begin
				cmd.a_sel = A_BASE;
				cmd.b_sel = B_CB;
			end
			S_K_COPY: cmd.b_sel = B_PACC;
			S_E_FIN: begin
				cmd.a_sel = A_HEAD;
				cmd.b_sel = B_PACC;
			end
			S_PUBLISH: begin
				is_mul      = 1'b0;
				cmd.publish = out_free;
				cmd.err     = err_q;
			end
			default: is_mul = 1'b0;
		endcase
		cmd.start = is_mul && !busy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_ENCRYPT;
			err_q   <= 1'b0;
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			// While publishing, the output register is refilled instead of cleared.
			if (valid_q && m_tready && state_q != S_PUBLISH)
				valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= op;
						err_q <= bad_mode;
						if (bad_mode || stat.n_small)
							state_q <= S_PUBLISH;
						else if (op == OP_ENCRYPT)
							state_q <= S_E_HEAD;
						else
							state_q <= S_B_CA;
					end
				end
				S_P_TEST: begin
					if (!stat.exp_zero)
						state_q <= stat.exp_bit0 ? S_P_MUL : S_P_SQR;
					else begin
						case (op_q)
							OP_ENCRYPT: state_q <= S_E_FIN;
							OP_DECRYPT: state_q <= S_D_DIV;
							default:    state_q <= S_K_COPY;
						endcase
					end
				end
				S_PUBLISH: begin
					if (out_free) begin
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					if (!busy_q)
						busy_q <= 1'b1;
					else if (stat.mul_done) begin
						busy_q  <= 1'b0;
						state_q <= after_mul;
					end
				end
			endcase
		end
	end
endmodule

@@ hw/rtl/paillier_cipher_unit_top.sv @@
// Paillier cipher unit, one item at a time through a shared bit-serial modular multiplier.
// Each modular multiplication is a start command followed by 32 bit steps of the multiplier.
// An item runs two or three fixed multiplications, plus one squaring per exponent bit and
// one multiplication per set exponent bit.
// Mode errors and n below 2 skip the multiplier. A new item is taken once the previous one is output.
// Reset (arst_n low, asynchronous) sets mode 0, n = 2, lambda = 0, mu = 0, drops output valid.
`include "paillier_cipher_unit_top_defines.svh"

module paillier_cipher_unit_top #(
	parameter int N_BITS = pcu_pkg::N_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// operation[1:0], plaintext[17:2], random_r[33:18], cipher_a[65:34],
	// cipher_b[97:66], scalar_k[113:98], zero padding above
	input  logic [pcu_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// result_value[31:0], status[32], zero padding above
	output logic [pcu_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pcu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pcu_pkg::DATA_W-1:0]         cfg_data
);
	import pcu_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	pcu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (op_t'(s_tdata[OP_W-1:0])),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pcu_datapath #(.N_BITS(N_BITS)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata)
	);

	`PCU_ASSERT_NOW(a_err_zero, m_tvalid && m_tdata[CIPH_W], m_tdata[CIPH_W-1:0] == '0)
	`PCU_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)
	`PCU_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid))
endmodule

@@ sim/tb_paillier_cipher_unit_top.sv @@
`timescale 1ns / 100ps

module tb_paillier_cipher_unit_top;
	import pcu_pkg::*;

	typedef struct {
		op_t         op;
		logic [15:0] m;
		logic [15:0] r;
		logic [31:0] ca;
		logic [31:0] cb;
		logic [15:0] k;
	} cipher_req_t;

	typedef struct {
		logic [31:0] value;
		logic        status;
	} cipher_res_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [DATA_W-1:0]      cfg_data;

	cipher_req_t pending_reqs[$];
	cipher_res_t expected_results[$];
	cipher_req_t next_req;
	int          accepted_cnt;
	int          error_cnt;

	// Copy of the key registers as the block should hold them.
	logic        key_mode;
	logic [15:0] key_n;
	logic [15:0] key_lambda;
	logic [15:0] key_mu;

	paillier_cipher_unit_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint unsigned mod_power(longint unsigned base, longint unsigned ex,
			longint unsigned md);
		longint unsigned acc;
		acc = 1 % md;
		base = base % md;
		while (ex != 0) begin
			if (ex[0])
				acc = (acc * base) % md;
			ex = ex >> 1;
			base = (base * base) % md;
		end
		return acc;
	endfunction

	function automatic longint mod_inverse(longint a, longint md);
		longint t0, t1, r0, r1, q, tmp;
		t0 = 0;
		t1 = 1;
		r0 = md;
		r1 = a % md;
		while (r1 != 0) begin
			q = r0 / r1;
			tmp = t0 - q * t1;
			t0 = t1;
			t1 = tmp;
			tmp = r0 - q * r1;
			r0 = r1;
			r1 = tmp;
		end
		if (t0 < 0)
			t0 = t0 + md;
		return t0;
	endfunction

	function automatic cipher_res_t cipher_outcome(cipher_req_t q);
		cipher_res_t     res;
		longint unsigned n, n2, head, x, l;
		n = key_n;
		n2 = n * n;
		res.value = '0;
		res.status = 1'b0;
		if ((q.op == OP_ENCRYPT && key_mode) || (q.op == OP_DECRYPT && !key_mode)) begin
			res.status = 1'b1;
		end else if (n >= 2) begin
			case (q.op)
				OP_ENCRYPT: begin
					head = (n * q.m + 1) % n2;
					res.value = 32'((head * mod_power(q.r, n, n2)) % n2);
				end
				OP_DECRYPT: begin
					x = mod_power(q.ca, key_lambda, n2);
					l = (x == 0) ? 0 : (x - 1) / n;
					res.value = 32'((l * key_mu) % n);
				end
				OP_ADD: begin
					res.value = 32'(((q.ca % n2) * (q.cb % n2)) % n2);
				end
				default: begin
					res.value = 32'(mod_power(q.ca, q.k, n2));
				end
			endcase
		end
		return res;
	endfunction

	// Sender: new item whenever the slot is free, holding off by the current idle rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			accepted_cnt <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				next_req.op = op_t'(s_tdata[1:0]);
				next_req.m = s_tdata[17:2];
				next_req.r = s_tdata[33:18];
				next_req.ca = s_tdata[65:34];
				next_req.cb = s_tdata[97:66];
				next_req.k = s_tdata[113:98];
				expected_results.push_back(cipher_outcome(next_req));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >=
						(accepted_cnt < 450 ? 20 : accepted_cnt < 900 ? 83 : 0)) begin
					next_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'b0, next_req.k, next_req.cb, next_req.ca, next_req.r,
						next_req.m, next_req.op};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each accepted result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		cipher_res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result %h", m_tdata);
					error_cnt++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[31:0] !== want.value) begin
						$error("result_value expected %h actual %h", want.value, m_tdata[31:0]);
						error_cnt++;
					end
					if (m_tdata[32] !== want.status) begin
						$error("status expected %b actual %b", want.status, m_tdata[32]);
						error_cnt++;
					end
				end
			end
			m_tready <= $urandom_range(99) >=
				(accepted_cnt < 450 ? 83 : accepted_cnt < 900 ? 20 : 0);
		end
	end

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MODE:   key_mode = val[0];
			CFG_N:      key_n = val;
			CFG_LAMBDA: key_lambda = val;
			default:    key_mu = val;
		endcase
	endtask

	task automatic load_keys(logic mode, logic [15:0] n, logic [15:0] lam, logic [15:0] mu);
		wait_idle();
		write_reg(CFG_MODE, {15'b0, mode});
		write_reg(CFG_N, n);
		write_reg(CFG_LAMBDA, lam);
		write_reg(CFG_MU, mu);
	endtask

	task automatic send(op_t op, logic [15:0] m, logic [15:0] r, logic [31:0] ca,
			logic [31:0] cb, logic [15:0] k);
		cipher_req_t q;
		q.op = op;
		q.m = m;
		q.r = r;
		q.ca = ca;
		q.cb = cb;
		q.k = k;
		pending_reqs.push_back(q);
	endtask

	function automatic logic [31:0] rand_cipher();
		longint unsigned n2;
		n2 = longint'(key_n) * key_n;
		if (n2 == 0 || $urandom_range(9) == 0)
			return $urandom;
		return 32'($urandom % n2);
	endfunction

	task automatic random_items(int count);
		int          sel;
		op_t         op;
		logic [15:0] m;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			if (sel < 40)
				op = key_mode ? OP_DECRYPT : OP_ENCRYPT;
			else if (sel < 65)
				op = OP_ADD;
			else if (sel < 90)
				op = OP_SCALAR;
			else
				op = key_mode ? OP_ENCRYPT : OP_DECRYPT;
			m = (key_n > 1 && $urandom_range(9) != 0) ? 16'($urandom % key_n) : 16'($urandom);
			send(op, m, 16'($urandom), rand_cipher(), rand_cipher(),
				$urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(255)));
		end
	endtask

	initial begin
		int p_list[6];
		int q_list[6];
		int p, q, n, lam, g;
		p_list = '{3, 11, 251, 17, 257, 2};
		q_list = '{5, 13, 241, 19, 251, 3};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_cnt = 0;
		key_mode = 1'b0;
		key_n = 16'd2;
		key_lambda = '0;
		key_mu = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Values straight out of reset.
		send(OP_ENCRYPT, 16'd1, 16'd3, '0, '0, '0);
		send(OP_DECRYPT, '0, '0, 32'd3, '0, '0);
		send(OP_ADD, '0, '0, 32'd3, 32'd3, '0);
		send(OP_SCALAR, '0, '0, 32'd3, '0, 16'd5);

		// Small key, field extremes and the zero exponent.
		load_keys(1'b0, 16'd15, 16'd4, 16'd4);
		send(OP_ENCRYPT, '0, '0, '0, '0, '0);
		send(OP_ENCRYPT, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
		send(OP_ENCRYPT, 16'd7, 16'd2, '0, '0, '0);
		send(OP_ADD, '0, '0, 32'hFFFFFFFF, 32'hFFFFFFFF, '0);
		send(OP_SCALAR, '0, '0, 32'hFFFFFFFF, '0, '0);
		send(OP_SCALAR, '0, '0, 32'd7, '0, 16'hFFFF);
		send(OP_DECRYPT, '0, '0, 32'd16, '0, '0);

		// Decrypt side: a power of zero, unreduced ciphertext, wrong-mode encrypt.
		load_keys(1'b1, 16'd15, 16'd4, 16'd4);
		send(OP_DECRYPT, '0, '0, '0, '0, '0);
		send(OP_DECRYPT, '0, '0, 32'hFFFFFFFF, '0, '0);
		send(OP_DECRYPT, '0, '0, 32'd151, '0, '0);
		send(OP_ENCRYPT, 16'd3, 16'd2, '0, '0, '0);
		send(OP_ADD, '0, '0, 32'd100, 32'd200, '0);

		// Modulus below two.
		load_keys(1'b0, 16'd1, 16'hFFFF, 16'hFFFF);
		send(OP_ENCRYPT, 16'd1, 16'd1, '0, '0, '0);
		send(OP_DECRYPT, '0, '0, 32'd5, '0, '0);
		send(OP_ADD, '0, '0, 32'd5, 32'd6, '0);
		load_keys(1'b1, 16'd0, 16'd1, 16'd1);
		send(OP_DECRYPT, '0, '0, 32'd5, '0, '0);
		send(OP_SCALAR, '0, '0, 32'd5, '0, 16'd3);

		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 6) begin
				load_keys(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
			end else if (ph == 9) begin
				load_keys(1'b0, 16'hFFFF, 16'd0, 16'd0);
			end else begin
				p = p_list[ph % 6];
				q = q_list[ph % 6];
				n = p * q;
				lam = p - 1;
				g = q - 1;
				while (g != 0) begin
					int t;
					t = lam % g;
					lam = g;
					g = t;
				end
				lam = (p - 1) * (q - 1) / lam;
				load_keys(ph[0], 16'(n), 16'(lam), 16'(mod_inverse(lam % n, n)));
			end
			random_items(112);
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (error_cnt == 0)
			$display("tb_paillier_cipher_unit_top: PASS");
		else
			$display("tb_paillier_cipher_unit_top: FAIL");
		$finish;
	end

	initial begin
		#80_000_000;
		$display("tb_paillier_cipher_unit_top: FAIL");
		$finish;
	end

endmodule
